// File: hw/rtl/pit_pkg.sv
package pit_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_e;

  localparam logic [7:0] REG_WINDOW_BASE = 8'd0;
  localparam logic [7:0] OFS_STATUS      = REG_WINDOW_BASE;
  localparam logic [7:0] OFS_STOP        = REG_WINDOW_BASE + 8'd4;
  localparam logic [7:0] OFS_CLEAR_INT   = REG_WINDOW_BASE + 8'd8;
  localparam logic [7:0] OFS_INTERVAL    = REG_WINDOW_BASE + 8'd12;
  localparam logic [7:0] OFS_ONESHOT     = REG_WINDOW_BASE + 8'd16;
  localparam logic [7:0] OFS_PERIODIC    = REG_WINDOW_BASE + 8'd20;

  localparam logic [31:0] STAT_ACTIVE  = 32'h1;
  localparam logic [31:0] STAT_PENDING = 32'h2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
    logic [2:0]  access_bytes;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
  } rsp_t;

endpackage

// File: hw/rtl/pit_if.sv
interface pit_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  reg_offset;
  logic [31:0] write_data;
  logic [2:0]  access_bytes;

  modport source (output valid, req_type, reg_offset, write_data, access_bytes, input ready);
  modport sink   (input valid, req_type, reg_offset, write_data, access_bytes, output ready);
endinterface

interface pit_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level;

  modport source (output valid, read_data, irq_level, input ready);
  modport sink   (input valid, read_data, irq_level, output ready);
endinterface

// File: hw/rtl/pit_in_reg.sv
module pit_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  pit_pkg::req_t req_data_i,
  input  logic          take_i,
  output logic          advance_o,
  output pit_pkg::req_t req_data_o
);

  logic          valid_q, valid_d;
  pit_pkg::req_t data_q;

  assign advance_o   = valid_q && take_i;
  assign req_ready_o = !valid_q || take_i;
  assign req_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (req_valid_i && req_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      data_q <= req_data_i;
    end
  end

endmodule

// File: hw/rtl/pit_core.sv
module pit_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  pit_pkg::req_t req_i,
  output pit_pkg::rsp_t rsp_o
);

  logic        active_q, active_d;
  logic        pending_q, pending_d;
  logic        periodic_q, periodic_d;
  logic [31:0] interval_q, interval_d;
  logic [31:0] count_q, count_d;
  logic [31:0] reload_q, reload_d;
  logic [31:0] rdata;
  logic        word_acc;
  logic        act;

  // widths four to seven all count as word accesses
  assign word_acc = req_i.access_bytes[2];
  assign act      = (req_i.write_data != 32'd0);

  always_comb begin
    active_d   = active_q;
    pending_d  = pending_q;
    periodic_d = periodic_q;
    interval_d = interval_q;
    count_d    = count_q;
    reload_d   = reload_q;
    rdata      = 32'd0;
    unique case (pit_pkg::req_e'(req_i.req_type))
      pit_pkg::REQ_TICK: begin
        if (active_q) begin
          if (count_q > 32'd1) begin
            count_d = count_q - 32'd1;
          end else begin
            pending_d = 1'b1;
            if (periodic_q) begin
              count_d = reload_q;
            end else begin
              active_d = 1'b0;
              count_d  = 32'd0;
            end
          end
        end
      end
      pit_pkg::REQ_READ, pit_pkg::REQ_WRITE: begin
        if (word_acc) begin
          unique case (req_i.reg_offset)
            pit_pkg::OFS_STATUS: begin
              rdata = (active_q ? pit_pkg::STAT_ACTIVE : 32'd0) |
                      (pending_q ? pit_pkg::STAT_PENDING : 32'd0);
            end
            pit_pkg::OFS_INTERVAL: begin
              if (req_i.req_type == pit_pkg::REQ_WRITE && act) begin
                interval_d = req_i.write_data;
                rdata      = req_i.write_data;
              end else begin
                rdata = interval_q;
              end
            end
            pit_pkg::OFS_ONESHOT, pit_pkg::OFS_PERIODIC: begin
              if (req_i.req_type == pit_pkg::REQ_WRITE && act) begin
                // latch the interval as it stands before this request
                periodic_d = (req_i.reg_offset == pit_pkg::OFS_PERIODIC);
                reload_d   = interval_q;
                count_d    = interval_q;
                active_d   = 1'b1;
              end
            end
            pit_pkg::OFS_STOP: begin
              if (req_i.req_type == pit_pkg::REQ_WRITE && act) begin
                active_d = 1'b0;
              end
            end
            pit_pkg::OFS_CLEAR_INT: begin
              if (req_i.req_type == pit_pkg::REQ_WRITE && act) begin
                pending_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.read_data = rdata;
  assign rsp_o.irq_level = pending_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      pending_q  <= 1'b0;
      periodic_q <= 1'b0;
      interval_q <= 32'd0;
      count_q    <= 32'd0;
      reload_q   <= 32'd0;
    end else if (advance_i) begin
      active_q   <= active_d;
      pending_q  <= pending_d;
      periodic_q <= periodic_d;
      interval_q <= interval_d;
      count_q    <= count_d;
      reload_q   <= reload_d;
    end
  end

endmodule

// File: hw/rtl/pit_out_reg.sv
module pit_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  pit_pkg::rsp_t rsp_i,
  output logic          take_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output pit_pkg::rsp_t rsp_o
);

  logic          valid_q, valid_d;
  pit_pkg::rsp_t data_q;

  // room for a new result when empty or when the held one leaves now
  assign take_o      = !valid_q || rsp_ready_i;
  assign rsp_valid_o = valid_q;
  assign rsp_o       = data_q;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      data_q <= rsp_i;
    end
  end

endmodule

// File: hw/rtl/interval_timer_registers.sv
// Interval timer with a six-word register window. Each request (a time tick, a
// register read or a register write) yields exactly one response carrying the
// read data and the interrupt level after the request has acted. One request
// is taken every cycle: it is captured in an input register, evaluated against
// the timer state by a single compare-and-decrement path, and its response is
// held in an output register, so throughput is one request per cycle as long as
// the response side keeps up.
module interval_timer_registers (
  input  logic      clk_i,
  input  logic      rst_ni,
  pit_req_if.sink   req_i,
  pit_rsp_if.source rsp_o
);

  pit_pkg::req_t req_in;
  pit_pkg::req_t req_q;
  pit_pkg::rsp_t rsp_d;
  pit_pkg::rsp_t rsp_q;
  logic          take;
  logic          advance;

  assign req_in.req_type     = req_i.req_type;
  assign req_in.reg_offset   = req_i.reg_offset;
  assign req_in.write_data   = req_i.write_data;
  assign req_in.access_bytes = req_i.access_bytes;

  pit_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_data_i  (req_in),
    .take_i      (take),
    .advance_o   (advance),
    .req_data_o  (req_q)
  );

  pit_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (req_q),
    .rsp_o     (rsp_d)
  );

  pit_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .rsp_i       (rsp_d),
    .take_o      (take),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_q)
  );

  assign rsp_o.read_data = rsp_q.read_data;
  assign rsp_o.irq_level = rsp_q.irq_level;

endmodule

// File: hw/rtl/pit_checker.sv
module pit_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_read_data_i,
  input logic        rsp_irq_level_i
);

  // an empty response slot always lets a request in
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request blocked while response slot is empty");

  // a response being taken frees the pipeline for a new request
  a_ready_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_ready_i |-> req_ready_i)
    else $error("request blocked while response drains");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("stalled response dropped");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_read_data_i) && $stable(rsp_irq_level_i))
    else $error("stalled response changed");

  // an accepted request leads to a pending response in the output register
  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |-> ##2 rsp_valid_i)
    else $error("accepted request produced no response");

endmodule

bind interval_timer_registers pit_checker u_pit_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_read_data_i (rsp_o.read_data),
  .rsp_irq_level_i (rsp_o.irq_level)
);

// File: verif/tb_interval_timer_registers.sv
`timescale 1ns / 100ps

module tb_interval_timer_registers;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [2:0]  WORD_BYTES   = 3'd4;
  localparam int unsigned RANDOM_ITEMS = 1330;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk_i;
  logic rst_ni;

  pit_req_if req_if ();
  pit_rsp_if rsp_if ();

  interval_timer_registers i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // timer state as the block should hold it
  logic        t_active;
  logic        t_pending;
  logic        t_periodic;
  logic [31:0] t_interval;
  logic [31:0] t_count;
  logic [31:0] t_reload;

  pit_pkg::rsp_t awaited_rsp[$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   sent_count;
  int unsigned   burst_left;
  logic          sender_gaps_on;
  int unsigned   rsp_stall_mode;
  int unsigned   hold_asked;
  int unsigned   hold_given;
  int unsigned   hold_left;
  logic [15:0]   stall_pattern;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void start_countdown(input logic periodic);
    t_periodic = periodic;
    t_reload   = t_interval;
    t_count    = t_interval;
    t_active   = 1'b1;
  endfunction

  // Apply one request to the timer state and return the response it yields.
  function automatic pit_pkg::rsp_t timer_response(input pit_pkg::req_t r);
    pit_pkg::rsp_t rsp;
    logic          act;
    logic [31:0]   val;
    act = (r.req_type == pit_pkg::REQ_WRITE) && (r.write_data != '0);
    val = '0;
    case (r.req_type)
      pit_pkg::REQ_TICK: begin
        if (t_active) begin
          if (t_count > 32'd1) begin
            t_count = t_count - 32'd1;
          end else begin
            t_pending = 1'b1;
            if (t_periodic) begin
              t_count = t_reload;
            end else begin
              t_active = 1'b0;
              t_count  = '0;
            end
          end
        end
      end
      pit_pkg::REQ_READ, pit_pkg::REQ_WRITE: begin
        if (r.access_bytes >= WORD_BYTES) begin
          case (r.reg_offset)
            pit_pkg::OFS_STATUS: begin
              val = (t_active ? pit_pkg::STAT_ACTIVE : '0) |
                    (t_pending ? pit_pkg::STAT_PENDING : '0);
            end
            pit_pkg::OFS_INTERVAL: begin
              if (act) t_interval = r.write_data;
              val = t_interval;
            end
            pit_pkg::OFS_ONESHOT: begin
              if (act) start_countdown(1'b0);
            end
            pit_pkg::OFS_PERIODIC: begin
              if (act) start_countdown(1'b1);
            end
            pit_pkg::OFS_STOP: begin
              if (act) t_active = 1'b0;
            end
            pit_pkg::OFS_CLEAR_INT: begin
              if (act) t_pending = 1'b0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    rsp.read_data = val;
    rsp.irq_level = t_pending;
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Capture accepted requests and check responses in acceptance order.
  always @(posedge clk_i) begin
    pit_pkg::rsp_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        awaited_rsp.push_back(timer_response(pit_pkg::req_t'{
          req_type:     req_if.req_type,
          reg_offset:   req_if.reg_offset,
          write_data:   req_if.write_data,
          access_bytes: req_if.access_bytes}));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("unexpected response", rsp_if.read_data, '0);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_if.read_data !== want.read_data) begin
            report_mismatch("read_data", rsp_if.read_data, want.read_data);
          end
          if (rsp_if.irq_level !== want.irq_level) begin
            report_mismatch("irq_level", {31'd0, rsp_if.irq_level}, {31'd0, want.irq_level});
          end
        end
      end
    end
  end

  // Response side: long hold-offs on request, otherwise one of several stall patterns.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (hold_asked != hold_given) begin
      hold_given++;
      hold_left = HOLD_CYCLES - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      case (rsp_stall_mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        2: begin
          rsp_if.ready <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
        default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] nonzero_word();
    logic [31:0] v;
    do v = $urandom(); while (v == '0);
    return v;
  endfunction

  // Offer one request, idling between bursts, and hold until it is taken.
  task automatic send_req(input logic [1:0] kind, input logic [7:0] ofs,
                          input logic [31:0] data, input logic [2:0] width);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.reg_offset   <= ofs;
    req_if.write_data   <= data;
    req_if.access_bytes <= width;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic tick();
    send_req(pit_pkg::REQ_TICK, 8'($urandom_range(0, 255)), $urandom(),
             3'($urandom_range(0, 7)));
  endtask

  task automatic reg_read(input logic [7:0] ofs);
    send_req(pit_pkg::REQ_READ, ofs, $urandom(), WORD_BYTES);
  endtask

  task automatic reg_write(input logic [7:0] ofs, input logic [31:0] data);
    send_req(pit_pkg::REQ_WRITE, ofs, data, WORD_BYTES);
  endtask

  task automatic noise_req();
    send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom(),
             3'($urandom_range(0, 7)));
  endtask

  task automatic test_reset_values();
    reg_read(pit_pkg::OFS_STATUS);
    reg_read(pit_pkg::OFS_INTERVAL);
    tick();
  endtask

  task automatic test_oneshot();
    reg_write(pit_pkg::OFS_INTERVAL, 32'hFFFF_FFFF);
    reg_write(pit_pkg::OFS_INTERVAL, 32'd2);
    reg_write(pit_pkg::OFS_ONESHOT, 32'h8000_0000);
    tick();
    tick();
    reg_read(pit_pkg::OFS_STATUS);
    tick();
    reg_write(pit_pkg::OFS_CLEAR_INT, '0);
    reg_write(pit_pkg::OFS_CLEAR_INT, 32'd1);
  endtask

  task automatic test_periodic();
    reg_write(pit_pkg::OFS_INTERVAL, '0);
    reg_write(pit_pkg::OFS_PERIODIC, 32'd1);
    tick();
    // new interval must not reach the running countdown
    reg_write(pit_pkg::OFS_INTERVAL, 32'd2);
    tick();
    reg_write(pit_pkg::OFS_PERIODIC, 32'hFFFF_FFFF);
    tick();
    tick();
    reg_write(pit_pkg::OFS_STOP, 32'd1);
    reg_write(pit_pkg::OFS_STOP, 32'd1);
    reg_read(pit_pkg::OFS_STATUS);
  endtask

  task automatic test_odd_accesses();
    for (int w = 0; w < 4; w++) begin
      send_req(pit_pkg::REQ_WRITE, pit_pkg::OFS_INTERVAL, 32'd7, w[2:0]);
    end
    send_req(pit_pkg::REQ_READ, pit_pkg::OFS_INTERVAL, '0, 3'd7);
    reg_write(pit_pkg::OFS_STATUS, 32'd3);
    reg_read(8'hFF);
    reg_read(8'd13);
    send_req(REQ_UNUSED, pit_pkg::OFS_INTERVAL, 32'd9, WORD_BYTES);
    reg_write(pit_pkg::OFS_INTERVAL, '0);
    reg_write(pit_pkg::OFS_ONESHOT, '0);
  endtask

  // Program, start and run the timer, with operations mixed into the ticks.
  task automatic timer_sequence();
    logic [31:0] ivl;
    int unsigned steps;
    int unsigned pick;
    case ($urandom_range(0, 9))
      0: ivl = $urandom();
      1: ivl = '0;
      default: ivl = $urandom_range(1, 6);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      send_req(pit_pkg::REQ_WRITE, pit_pkg::OFS_INTERVAL, ivl, 3'($urandom_range(0, 7)));
    end else begin
      reg_write(pit_pkg::OFS_INTERVAL, ivl);
    end
    reg_write($urandom_range(0, 1) ? pit_pkg::OFS_PERIODIC : pit_pkg::OFS_ONESHOT,
              nonzero_word());
    steps = $urandom_range(1, 15);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) tick();
      else if (pick < 75) reg_read(pit_pkg::OFS_STATUS);
      else if (pick < 80) reg_read(pit_pkg::OFS_INTERVAL);
      else if (pick < 85) reg_write(pit_pkg::OFS_INTERVAL, $urandom_range(0, 8));
      else if (pick < 90) reg_write(pit_pkg::OFS_CLEAR_INT,
                                    $urandom_range(0, 3) ? nonzero_word() : '0);
      else if (pick < 93) reg_write(pit_pkg::OFS_STOP, nonzero_word());
      else if (pick < 96) reg_write($urandom_range(0, 1) ? pit_pkg::OFS_PERIODIC
                                                         : pit_pkg::OFS_ONESHOT,
                                    nonzero_word());
      else noise_req();
    end
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    stop_at = sent_count + RANDOM_ITEMS;
    while (sent_count < stop_at) begin
      rsp_stall_mode = $urandom_range(0, 3);
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 8) begin
        timer_sequence();
      end else begin
        repeat ($urandom_range(1, 4)) noise_req();
      end
    end
  endtask

  // Stall the response side long enough that the block fills and stops taking requests.
  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    rsp_stall_mode = 0;
    hold_asked++;
    repeat (2) timer_sequence();
    repeat (20) noise_req();
    hold_asked++;
    repeat (30) tick();
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = pit_pkg::REQ_TICK;
    req_if.reg_offset   = '0;
    req_if.write_data   = '0;
    req_if.access_bytes = '0;
    rsp_if.ready        = 1'b0;
    t_active            = 1'b0;
    t_pending           = 1'b0;
    t_periodic          = 1'b0;
    t_interval          = '0;
    t_count             = '0;
    t_reload            = '0;
    mismatch_count      = 0;
    cycle_count         = 0;
    sent_count          = 0;
    burst_left          = 0;
    sender_gaps_on      = 1'b1;
    rsp_stall_mode      = 1;
    hold_asked          = 0;
    hold_given          = 0;
    hold_left           = 0;
    stall_pattern       = 16'b1011_0111_1100_1110;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_oneshot();
    test_periodic();
    test_odd_accesses();
    test_backpressure();
    test_random_traffic();
    test_backpressure();

    req_if.valid <= 1'b0;
    rsp_stall_mode = 1;
    @(posedge clk_i);
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/pit_pkg.sv
hw/rtl/pit_if.sv
hw/rtl/pit_in_reg.sv
hw/rtl/pit_core.sv
hw/rtl/pit_out_reg.sv
hw/rtl/interval_timer_registers.sv
hw/rtl/pit_checker.sv
verif/tb_interval_timer_registers.sv
